// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled while rst_n low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SBQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sbq_pkg.sv -----
// ----------------------------------------------------------------------------
// sbq_pkg
// Widths, codes, control word layout and microcode ROM for the stereo
// biquad cascade equaliser.
// ----------------------------------------------------------------------------
`default_nettype none

package sbq_pkg;

  // Sizing
  localparam int MAX_STAGES = 8;
  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 32;
  localparam int FRAC_W     = COEF_W - 4;
  localparam int NCOEF      = 5;
  localparam int CNT_W      = 4;   // stage count registers
  localparam int STAGE_W    = 3;   // stage field of a coefficient beat
  localparam int SEL_W      = 3;

  localparam int STC_W   = $clog2(MAX_STAGES + 1);
  localparam int HROWS   = 2 * MAX_STAGES;
  localparam int HADDR_W = $clog2(HROWS);
  localparam int HROW_W  = 4 * SAMPLE_W;
  localparam int CWORDS  = HROWS * NCOEF;
  localparam int CADDR_W = $clog2(CWORDS);

  // Datapath
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int RND_W  = ACC_W - FRAC_W;

  localparam logic signed [COEF_W-1:0] COEF_ONE =
    {{(COEF_W - FRAC_W - 1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};
  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W - FRAC_W){1'b0}}, 1'b1, {(FRAC_W - 1){1'b0}}};
  localparam logic signed [RND_W-1:0] SAT_HI =
    {{(RND_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [RND_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

  // Stream packing
  localparam int IN_CH_LSB   = 0;
  localparam int IN_STG_LSB  = 1;
  localparam int IN_SEL_LSB  = IN_STG_LSB + STAGE_W;
  localparam int IN_COEF_LSB = IN_SEL_LSB + SEL_W;
  localparam int IN_SL_LSB   = IN_COEF_LSB + COEF_W;
  localparam int IN_SR_LSB   = IN_SL_LSB + SAMPLE_W;
  localparam int IN_BITS     = IN_SR_LSB + SAMPLE_W;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((2 * SAMPLE_W + 7) / 8) * 8;

  // Beat kinds
  localparam logic OP_COEF_WR = 1'b0;
  localparam logic OP_SAMPLE  = 1'b1;

  // Register indexes
  localparam logic REG_STAGES_LEFT  = 1'b0;
  localparam logic REG_STAGES_RIGHT = 1'b1;

  // Coefficient / operand slots
  localparam logic [SEL_W-1:0] K_B0 = 3'd0;
  localparam logic [SEL_W-1:0] K_B1 = 3'd1;
  localparam logic [SEL_W-1:0] K_B2 = 3'd2;
  localparam logic [SEL_W-1:0] K_A1 = 3'd3;
  localparam logic [SEL_W-1:0] K_A2 = 3'd4;

  // Microprogram addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] PC_TEST   = 4'd1;
  localparam logic [PC_W-1:0] PC_MUL_B0 = 4'd2;
  localparam logic [PC_W-1:0] PC_MUL_B1 = 4'd3;
  localparam logic [PC_W-1:0] PC_MUL_B2 = 4'd4;
  localparam logic [PC_W-1:0] PC_MUL_A1 = 4'd5;
  localparam logic [PC_W-1:0] PC_MUL_A2 = 4'd6;
  localparam logic [PC_W-1:0] PC_ACC_A2 = 4'd7;
  localparam logic [PC_W-1:0] PC_ROUND  = 4'd8;
  localparam logic [PC_W-1:0] PC_WB     = 4'd9;
  localparam logic [PC_W-1:0] PC_CHAN   = 4'd10;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;

  typedef enum logic [2:0] {SQ_NEXT, SQ_IDLE, SQ_TEST, SQ_JUMP, SQ_CHAN} seq_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
    logic    rnd_en;
  } mac_ctrl_t;

  typedef struct packed {
    seq_op_t          seq;
    logic [PC_W-1:0]  target;
    logic             coef_rd;
    logic [SEL_W-1:0] coef_k;
    logic             hist_rd;
    logic             hist_cap;
    logic [SEL_W-1:0] opnd_k;
    mac_ctrl_t        mac;
    logic             wb_en;
  } ucode_t;

  // Microcode ROM: one stage of one channel is TEST .. WB
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w            = '0;
    w.seq        = SQ_NEXT;
    w.mac.acc_op = ACC_HOLD;
    case (pc)
      PC_IDLE: begin
        w.seq = SQ_IDLE;
      end
      PC_TEST: begin
        w.seq     = SQ_TEST;
        w.target  = PC_CHAN;
        w.coef_rd = 1'b1;
        w.coef_k  = K_B0;
        w.hist_rd = 1'b1;
      end
      PC_MUL_B0: begin
        w.coef_rd    = 1'b1;
        w.coef_k     = K_B1;
        w.hist_cap   = 1'b1;
        w.opnd_k     = K_B0;
        w.mac.mul_en = 1'b1;
      end
      PC_MUL_B1: begin
        w.coef_rd    = 1'b1;
        w.coef_k     = K_B2;
        w.opnd_k     = K_B1;
        w.mac.mul_en = 1'b1;
        w.mac.acc_op = ACC_LOAD;
      end
      PC_MUL_B2: begin
        w.coef_rd    = 1'b1;
        w.coef_k     = K_A1;
        w.opnd_k     = K_B2;
        w.mac.mul_en = 1'b1;
        w.mac.acc_op = ACC_ADD;
      end
      PC_MUL_A1: begin
        w.coef_rd    = 1'b1;
        w.coef_k     = K_A2;
        w.opnd_k     = K_A1;
        w.mac.mul_en = 1'b1;
        w.mac.acc_op = ACC_ADD;
      end
      PC_MUL_A2: begin
        w.opnd_k     = K_A2;
        w.mac.mul_en = 1'b1;
        w.mac.acc_op = ACC_SUB;
      end
      PC_ACC_A2: begin
        w.mac.acc_op = ACC_SUB;
      end
      PC_ROUND: begin
        w.mac.rnd_en = 1'b1;
      end
      PC_WB: begin
        w.seq    = SQ_JUMP;
        w.target = PC_TEST;
        w.wb_en  = 1'b1;
      end
      PC_CHAN: begin
        w.seq = SQ_CHAN;
      end
      default: begin
        w.seq    = SQ_JUMP;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sbq_ram.sv -----
// ----------------------------------------------------------------------------
// sbq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/sbq_mac.sv -----
// ----------------------------------------------------------------------------
// sbq_mac
// Shared multiply-accumulate unit: registered product, exact accumulator,
// round half up to the sample grid, saturation to the sample range.
// ----------------------------------------------------------------------------
`default_nettype none

module sbq_mac (
  input  logic                                 clk,
  input  sbq_pkg::mac_ctrl_t                   ctrl,
  input  logic signed [sbq_pkg::COEF_W-1:0]    coef,
  input  logic signed [sbq_pkg::SAMPLE_W-1:0]  opnd,
  output logic signed [sbq_pkg::SAMPLE_W-1:0]  y,
  output logic                                 sat
);

  logic signed [sbq_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [sbq_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [sbq_pkg::ACC_W-1:0]  biased;
  logic signed [sbq_pkg::RND_W-1:0]  rnd_r, rnd_nxt;

  // product, one multiply per beat
  assign prod_nxt = sbq_pkg::PROD_W'(coef) * sbq_pkg::PROD_W'(opnd);

  // accumulate with sign from the microcode
  always_comb begin
    unique case (ctrl.acc_op)
      sbq_pkg::ACC_HOLD: acc_nxt = acc_r;
      sbq_pkg::ACC_LOAD: acc_nxt = sbq_pkg::ACC_W'(prod_r);
      sbq_pkg::ACC_ADD:  acc_nxt = acc_r + sbq_pkg::ACC_W'(prod_r);
      sbq_pkg::ACC_SUB:  acc_nxt = acc_r - sbq_pkg::ACC_W'(prod_r);
    endcase
  end

  // round half up, drop fraction bits
  assign biased  = acc_r + sbq_pkg::ROUND_HALF;
  assign rnd_nxt = sbq_pkg::RND_W'(biased >>> sbq_pkg::FRAC_W);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
    if (ctrl.rnd_en) begin
      rnd_r <= rnd_nxt;
    end
  end

  // saturate
  always_comb begin
    if (rnd_r > sbq_pkg::SAT_HI) begin
      y   = sbq_pkg::SMP_MAX;
      sat = 1'b1;
    end else if (rnd_r < sbq_pkg::SAT_LO) begin
      y   = sbq_pkg::SMP_MIN;
      sat = 1'b1;
    end else begin
      y   = rnd_r[sbq_pkg::SAMPLE_W-1:0];
      sat = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/stereo_biquad_cascade_eq.sv -----
// ----------------------------------------------------------------------------
// stereo_biquad_cascade_eq
// Coefficient beat: written on acceptance, no result. Sample beat: a result
// once left, then right has run its active stages, held back while an untaken
// result waits; next beat taken in the cycle after the load. Single shared
// multiplier, nine microcode steps per active stage.
// Reset (rst_n low, synchronous) clears counts, valid bits and sequencer; all
// coefficients read as identity and all history as zero until written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stereo_biquad_cascade_eq (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // channel, stage, coef_select, coef_value, sample_left, sample_right
  input  logic [sbq_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tuser,   // op
  input  logic                              in_tlast,   // frame_end
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_left, out_right
  output logic [sbq_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tuser,  // clipped
  output logic                              out_tlast,  // frame_end_out
  // configuration
  input  logic                              cfg_wr_en,
  input  logic                              cfg_addr,
  input  logic [sbq_pkg::CNT_W-1:0]         cfg_wr_data
);

  // Input beat fields
  logic                                in_ch;
  logic [sbq_pkg::STAGE_W-1:0]         in_stage;
  logic [sbq_pkg::SEL_W-1:0]           in_sel;
  logic [sbq_pkg::COEF_W-1:0]          in_coef;
  logic signed [sbq_pkg::SAMPLE_W-1:0] in_sl;
  logic signed [sbq_pkg::SAMPLE_W-1:0] in_sr;
  logic                                in_accept;

  assign in_ch     = in_tdata[sbq_pkg::IN_CH_LSB];
  assign in_stage  = in_tdata[sbq_pkg::IN_STG_LSB +: sbq_pkg::STAGE_W];
  assign in_sel    = in_tdata[sbq_pkg::IN_SEL_LSB +: sbq_pkg::SEL_W];
  assign in_coef   = in_tdata[sbq_pkg::IN_COEF_LSB +: sbq_pkg::COEF_W];
  assign in_sl     = in_tdata[sbq_pkg::IN_SL_LSB +: sbq_pkg::SAMPLE_W];
  assign in_sr     = in_tdata[sbq_pkg::IN_SR_LSB +: sbq_pkg::SAMPLE_W];
  assign in_accept = in_tvalid & in_tready;

  // Registers
  logic [sbq_pkg::CNT_W-1:0]           stages_left_r, stages_right_r;
  logic [sbq_pkg::PC_W-1:0]            pc_r, pc_nxt;
  logic                                ch_r, ch_nxt;
  logic [sbq_pkg::STC_W-1:0]           st_r, st_nxt;
  logic                                clip_r, clip_nxt;
  logic signed [sbq_pkg::SAMPLE_W-1:0] x_r, x_nxt;
  logic signed [sbq_pkg::SAMPLE_W-1:0] left_r, left_nxt;
  logic signed [sbq_pkg::SAMPLE_W-1:0] right_in_r, right_in_nxt;
  logic                                fe_r, fe_nxt;
  logic [sbq_pkg::HROW_W-1:0]          hist_r, hist_nxt;
  logic                                hvld_r, hvld_nxt;
  logic                                cvld_r, cvld_nxt;
  logic [sbq_pkg::SEL_W-1:0]           ck_r, ck_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic signed [sbq_pkg::SAMPLE_W-1:0] out_left_r, out_left_nxt;
  logic signed [sbq_pkg::SAMPLE_W-1:0] out_right_r, out_right_nxt;
  logic                                out_clip_r, out_clip_nxt;
  logic                                out_last_r, out_last_nxt;
  logic [sbq_pkg::CWORDS-1:0]          cvalid_r;
  logic [sbq_pkg::HROWS-1:0]           hvalid_r;

  // Control
  sbq_pkg::ucode_t                     cw;
  logic [sbq_pkg::CNT_W-1:0]           cnt_raw;
  logic [sbq_pkg::STC_W-1:0]           n_cur;
  logic                                active;
  logic                                step_go;
  logic                                out_load;
  logic [sbq_pkg::HADDR_W-1:0]         row;
  logic [sbq_pkg::CADDR_W-1:0]         crd_addr;
  logic [sbq_pkg::CADDR_W-1:0]         cwr_addr;
  logic                                coef_ok;
  logic                                coef_we;
  logic                                coef_rd_en;
  logic                                hist_rd_en;

  // Datapath
  logic [sbq_pkg::COEF_W-1:0]          coef_rd_data;
  logic [sbq_pkg::HROW_W-1:0]          hist_rd_data;
  logic [sbq_pkg::HROW_W-1:0]          hist_wr_data;
  logic signed [sbq_pkg::COEF_W-1:0]   coef_eff;
  logic signed [sbq_pkg::SAMPLE_W-1:0] opnd;
  logic signed [sbq_pkg::SAMPLE_W-1:0] mac_y;
  logic                                mac_sat;
  logic signed [sbq_pkg::SAMPLE_W-1:0] h_x1, h_x2, h_y1, h_y2;

  assign cw = sbq_pkg::ucode_rom(pc_r);

  // Stage count of the channel in work, clamped to the store size
  assign cnt_raw = ch_r ? stages_right_r : stages_left_r;
  always_comb begin
    if (32'(cnt_raw) > 32'(sbq_pkg::MAX_STAGES)) begin
      n_cur = sbq_pkg::STC_W'(sbq_pkg::MAX_STAGES);
    end else begin
      n_cur = sbq_pkg::STC_W'(cnt_raw);
    end
  end

  assign active  = st_r < n_cur;
  assign step_go = (cw.seq != sbq_pkg::SQ_TEST) || active;

  // Store addressing: row = channel * MAX_STAGES + stage
  assign row = ch_r ? sbq_pkg::HADDR_W'(sbq_pkg::MAX_STAGES) + sbq_pkg::HADDR_W'(st_r)
                    : sbq_pkg::HADDR_W'(st_r);
  assign crd_addr = sbq_pkg::CADDR_W'(int'(row) * sbq_pkg::NCOEF + int'(cw.coef_k));
  assign cwr_addr = sbq_pkg::CADDR_W'((int'(in_ch) * sbq_pkg::MAX_STAGES + int'(in_stage))
                                      * sbq_pkg::NCOEF + int'(in_sel));

  // Coefficient write beat; bad slot or stage is dropped
  assign coef_ok = (int'(in_sel) < sbq_pkg::NCOEF) && (int'(in_stage) < sbq_pkg::MAX_STAGES);
  assign coef_we = in_accept && (in_tuser == sbq_pkg::OP_COEF_WR) && coef_ok;

  assign coef_rd_en = cw.coef_rd & step_go;
  assign hist_rd_en = cw.hist_rd & step_go;

  sbq_ram #(
    .WIDTH (sbq_pkg::COEF_W),
    .DEPTH (sbq_pkg::CWORDS)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (coef_we),
    .wr_addr (cwr_addr),
    .wr_data (in_coef),
    .rd_en   (coef_rd_en),
    .rd_addr (crd_addr),
    .rd_data (coef_rd_data)
  );

  // History row: {y2, y1, x2, x1}
  assign h_x1 = hist_r[0 +: sbq_pkg::SAMPLE_W];
  assign h_x2 = hist_r[sbq_pkg::SAMPLE_W +: sbq_pkg::SAMPLE_W];
  assign h_y1 = hist_r[2 * sbq_pkg::SAMPLE_W +: sbq_pkg::SAMPLE_W];
  assign h_y2 = hist_r[3 * sbq_pkg::SAMPLE_W +: sbq_pkg::SAMPLE_W];
  assign hist_wr_data = {h_y1, mac_y, h_x1, x_r};

  sbq_ram #(
    .WIDTH (sbq_pkg::HROW_W),
    .DEPTH (sbq_pkg::HROWS)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (cw.wb_en),
    .wr_addr (row),
    .wr_data (hist_wr_data),
    .rd_en   (hist_rd_en),
    .rd_addr (row),
    .rd_data (hist_rd_data)
  );

  // Unwritten coefficients read as identity
  always_comb begin
    if (cvld_r) begin
      coef_eff = coef_rd_data;
    end else if (ck_r == sbq_pkg::K_B0) begin
      coef_eff = sbq_pkg::COEF_ONE;
    end else begin
      coef_eff = '0;
    end
  end

  // Operand select
  always_comb begin
    unique case (cw.opnd_k)
      sbq_pkg::K_B1: opnd = h_x1;
      sbq_pkg::K_B2: opnd = h_x2;
      sbq_pkg::K_A1: opnd = h_y1;
      sbq_pkg::K_A2: opnd = h_y2;
      default:       opnd = x_r;
    endcase
  end

  sbq_mac u_mac (
    .clk  (clk),
    .ctrl (cw.mac),
    .coef (coef_eff),
    .opnd (opnd),
    .y    (mac_y),
    .sat  (mac_sat)
  );

  // Sequencer and datapath next state
  always_comb begin
    pc_nxt        = pc_r;
    ch_nxt        = ch_r;
    st_nxt        = st_r;
    clip_nxt      = clip_r;
    x_nxt         = x_r;
    left_nxt      = left_r;
    right_in_nxt  = right_in_r;
    fe_nxt        = fe_r;
    hist_nxt      = hist_r;
    hvld_nxt      = hvld_r;
    cvld_nxt      = cvld_r;
    ck_nxt        = ck_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_clip_nxt  = out_clip_r;
    out_last_nxt  = out_last_r;
    out_load      = 1'b0;

    if (hist_rd_en) begin
      hvld_nxt = hvalid_r[row];
    end
    if (coef_rd_en) begin
      cvld_nxt = cvalid_r[crd_addr];
      ck_nxt   = cw.coef_k;
    end
    if (cw.hist_cap) begin
      hist_nxt = hvld_r ? hist_rd_data : '0;
    end
    // stage write-back: output becomes next stage input
    if (cw.wb_en) begin
      x_nxt    = mac_y;
      clip_nxt = clip_r | mac_sat;
      st_nxt   = st_r + sbq_pkg::STC_W'(1);
    end

    case (cw.seq)
      sbq_pkg::SQ_IDLE: begin
        if (in_accept && (in_tuser == sbq_pkg::OP_SAMPLE)) begin
          pc_nxt       = sbq_pkg::PC_TEST;
          ch_nxt       = 1'b0;
          st_nxt       = '0;
          clip_nxt     = 1'b0;
          x_nxt        = in_sl;
          right_in_nxt = in_sr;
          fe_nxt       = in_tlast;
        end
      end
      sbq_pkg::SQ_NEXT: begin
        pc_nxt = pc_r + sbq_pkg::PC_W'(1);
      end
      sbq_pkg::SQ_TEST: begin
        pc_nxt = active ? pc_r + sbq_pkg::PC_W'(1) : cw.target;
      end
      sbq_pkg::SQ_JUMP: begin
        pc_nxt = cw.target;
      end
      sbq_pkg::SQ_CHAN: begin
        if (!ch_r) begin
          ch_nxt   = 1'b1;
          st_nxt   = '0;
          left_nxt = x_r;
          x_nxt    = right_in_r;
          pc_nxt   = sbq_pkg::PC_TEST;
        end else if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_left_nxt  = left_r;
          out_right_nxt = x_r;
          out_clip_nxt  = clip_r;
          out_last_nxt  = fe_r;
          pc_nxt        = sbq_pkg::PC_IDLE;
        end
      end
      default: begin
        pc_nxt = sbq_pkg::PC_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stages_left_r  <= '0;
      stages_right_r <= '0;
      pc_r           <= sbq_pkg::PC_IDLE;
      ch_r           <= 1'b0;
      st_r           <= '0;
      out_valid_r    <= 1'b0;
      cvalid_r       <= '0;
      hvalid_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          sbq_pkg::REG_STAGES_LEFT:  stages_left_r  <= cfg_wr_data;
          sbq_pkg::REG_STAGES_RIGHT: stages_right_r <= cfg_wr_data;
        endcase
      end
      pc_r        <= pc_nxt;
      ch_r        <= ch_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (coef_we) begin
        cvalid_r[cwr_addr] <= 1'b1;
      end
      if (cw.wb_en) begin
        hvalid_r[row] <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    clip_r      <= clip_nxt;
    x_r         <= x_nxt;
    left_r      <= left_nxt;
    right_in_r  <= right_in_nxt;
    fe_r        <= fe_nxt;
    hist_r      <= hist_nxt;
    hvld_r      <= hvld_nxt;
    cvld_r      <= cvld_nxt;
    ck_r        <= ck_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_clip_r  <= out_clip_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Ports
  assign in_tready  = (cw.seq == sbq_pkg::SQ_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = sbq_pkg::OUT_DATA_W'({out_right_r, out_left_r});
  assign out_tuser  = out_clip_r;
  assign out_tlast  = out_last_r;

  // Checks
  `SBQ_ASSERT_IMPL(a_out_free, out_load, (!out_valid_r || out_tready), "result overwritten")
  `SBQ_ASSERT_IMPL(a_stage_bound, 1'b1, (st_r <= sbq_pkg::STC_W'(sbq_pkg::MAX_STAGES)), "stage count out of range")
  `SBQ_ASSERT_IMPL(a_wb_in_store, cw.wb_en, (32'(st_r) < sbq_pkg::MAX_STAGES), "write-back beyond store")
  `SBQ_ASSERT_NEXT(a_sample_start, (in_accept && in_tuser == sbq_pkg::OP_SAMPLE), (pc_r == sbq_pkg::PC_TEST), "sample beat did not start sequence")

endmodule

`default_nettype wire
